@@ design/tpa_pkg.sv @@
// Shared types and constants for the triangle primitive assembler.
package tpa_pkg;

   localparam int unsigned FIELD_W        = 32;
   localparam int unsigned MODE_W         = 2;
   localparam int unsigned FILL_W         = 2;
   localparam int unsigned INDEX_BITS_DEF = 32;

   localparam logic [MODE_W-1:0] MODE_LIST  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STRIP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FAN   = 2'd2;

   localparam logic [FILL_W-1:0] FILL_EMPTY = 2'd0;
   localparam logic [FILL_W-1:0] FILL_ONE   = 2'd1;
   localparam logic [FILL_W-1:0] FILL_TWO   = 2'd2;

   localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [FIELD_W-1:0] vertex_index;
      logic [MODE_W-1:0]  primitive_mode;
      logic               group_start;
      logic [FIELD_W-1:0] material_id;
   } tpa_req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] corner_a;
      logic [FIELD_W-1:0] corner_b;
      logic [FIELD_W-1:0] corner_c;
      logic [FIELD_W-1:0] triangle_material;
      logic [FIELD_W-1:0] triangle_number;
   } tpa_rsp_type;

endpackage

@@ design/tpa_if.sv @@
// Valid/ready channel interfaces for vertex beats and triangle beats.
interface tpa_req_if;
   import tpa_pkg::*;
   logic        valid;
   logic        ready;
   tpa_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tpa_rsp_if;
   import tpa_pkg::*;
   logic        valid;
   logic        ready;
   tpa_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ design/triangle_primitive_assembler.sv @@
// A vertex beat that completes a triangle shows its triangle beat from the next cycle.
// Throughput: one vertex beat per cycle; a new beat is taken whenever the result register
// is empty or its triangle is taken in the same cycle.
// Only the single result register lies between the two: window update and emit are one level.
// Reset (synchronous, active high) clears the window, fill count, strip parity,
// triangle counter and result valid.
module triangle_primitive_assembler #(
   parameter int unsigned INDEX_BITS = tpa_pkg::INDEX_BITS_DEF
) (
   input logic  clock,
   input logic  reset,
   tpa_req_if.sink   req_bus,
   tpa_rsp_if.source rsp_bus
);
   import tpa_pkg::*;

   // Vertex window and group tracking
   logic [INDEX_BITS-1:0] older_ff, older_in;
   logic [INDEX_BITS-1:0] newer_ff, newer_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  odd_ff, odd_in;
   logic [FIELD_W-1:0]    emitted_ff, emitted_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   tpa_rsp_type           rsp_data_ff, rsp_data_in;

   logic                  req_ready;
   logic                  accept;
   logic [INDEX_BITS-1:0] vtx;
   logic [FILL_W-1:0]     fill_eff;
   logic                  odd_eff;
   logic                  emit;
   logic [INDEX_BITS-1:0] tri_a, tri_b, tri_c;

   // The result register frees up in the same cycle its beat is taken.
   assign req_ready       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready   = req_ready;
   assign accept          = req_bus.valid && req_ready;
   assign vtx             = req_bus.data.vertex_index[INDEX_BITS-1:0];

   // Group start wipes the fill count and parity before this vertex is placed.
   assign fill_eff = req_bus.data.group_start ? FILL_EMPTY : fill_ff;
   assign odd_eff  = req_bus.data.group_start ? 1'b0 : odd_ff;

   always_comb begin
      older_in = older_ff;
      newer_in = newer_ff;
      fill_in  = fill_ff;
      odd_in   = odd_ff;
      emit     = 1'b0;
      tri_a    = older_ff;
      tri_b    = newer_ff;
      tri_c    = vtx;
      if (accept) begin
         case (req_bus.data.primitive_mode)
            MODE_LIST, MODE_STRIP, MODE_FAN: begin
               fill_in = fill_eff;
               odd_in  = odd_eff;
               case (fill_eff)
                  FILL_EMPTY: begin
                     older_in = vtx;
                     fill_in  = FILL_ONE;
                  end
                  FILL_ONE: begin
                     newer_in = vtx;
                     fill_in  = FILL_TWO;
                  end
                  default: begin
                     // Full window: a triangle goes out in every mode.
                     emit = 1'b1;
                     case (req_bus.data.primitive_mode)
                        MODE_LIST: begin
                           fill_in = FILL_EMPTY;
                        end
                        MODE_STRIP: begin
                           // Odd strip triangles swap b and c to keep winding.
                           if (odd_eff) begin
                              tri_b = vtx;
                              tri_c = newer_ff;
                           end
                           older_in = newer_ff;
                           newer_in = vtx;
                           odd_in   = !odd_eff;
                        end
                        default: begin
                           // Fan: the anchor stays put, only the newer slot slides.
                           newer_in = vtx;
                        end
                     endcase
                  end
               endcase
            end
            default: begin
               // Unused mode code: beat is dropped with no state change.
            end
         endcase
      end
   end

   // Counter saturates; the number carried is the count before this triangle.
   assign emitted_in = (emit && emitted_ff != COUNT_MAX) ? emitted_ff + 1'b1 : emitted_ff;

   always_comb begin
      rsp_data_in.corner_a          = FIELD_W'(tri_a);
      rsp_data_in.corner_b          = FIELD_W'(tri_b);
      rsp_data_in.corner_c          = FIELD_W'(tri_c);
      rsp_data_in.triangle_material = req_bus.data.material_id;
      rsp_data_in.triangle_number   = emitted_ff;
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff     <= '0;
         newer_ff     <= '0;
         fill_ff      <= FILL_EMPTY;
         odd_ff       <= 1'b0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         fill_ff      <= fill_in;
         odd_ff       <= odd_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload loads only with a new triangle, so a stalled beat holds.
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Window never holds more than two vertices.
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("fill count out of range");

   // A triangle beat only appears right after a vertex was accepted.
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("triangle beat without a vertex beat");

   // A held triangle's number is one below the running count unless saturated.
   a_number_tracks_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.triangle_number + 1'b1 == emitted_ff)
                       || (emitted_ff == COUNT_MAX))
      else $error("triangle number out of step with counter");

   // Running count never goes backwards.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> emitted_ff >= $past(emitted_ff))
      else $error("triangle counter decreased");
`endif

endmodule
